>>> rtl/core/buddy_page_allocator_top_macros.svh
// Assertion macros for the buddy page allocator top level.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bpa_pkg.sv
// Shared types, codes and helpers of the buddy page allocator.
package bpa_pkg;

   localparam int FUNC_W   = 3;
   localparam int RANK_W   = 5;
   localparam int PAGE_W   = 13;
   localparam int STATUS_W = 2;
   localparam int BLOCK_W  = 12;
   localparam int VALUE_W  = 13;
   localparam int POOL_W   = 13;
   // wide enough for any block size, page index or pool size
   localparam int SIZE_W   = 18;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

   typedef enum logic [2:0] {
      OP_INIT  = 3'd0,
      OP_ALLOC = 3'd1,
      OP_FREE  = 3'd2,
      OP_QUERY = 3'd3,
      OP_COUNT = 3'd4,
      OP_BAD   = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                rank_ok;
      logic [RANK_W-1:0]   rank;
      logic [PAGE_W-1:0]   page;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic initialized;
   } stat_type;

   // pages held by a block of rank r
   function automatic logic [SIZE_W-1:0] rank_size(input logic [RANK_W-1:0] r);
      rank_size = SIZE_W'(1) << (r - RANK_W'(1));
   endfunction

endpackage

>>> rtl/core/bpa_front.sv
// Front end: decodes request words and queues them for the back end.
module bpa_front
   import bpa_pkg::*;
#(
   parameter int TOP_RANK = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [RANK_W-1:0]   req_rank,
   input  logic [PAGE_W-1:0]   req_page_index,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cmd_type             cmd
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     dec;
   logic        push, pop;

   always_comb begin
      dec.rank    = req_rank;
      dec.page    = req_page_index;
      dec.rank_ok = (req_rank != '0) && (req_rank <= RANK_W'(TOP_RANK));
      unique case (req_func)
         FUNC_INIT:  dec.op = OP_INIT;
         FUNC_ALLOC: dec.op = OP_ALLOC;
         FUNC_FREE:  dec.op = OP_FREE;
         FUNC_QUERY: dec.op = OP_QUERY;
         FUNC_COUNT: dec.op = OP_COUNT;
         default:    dec.op = OP_BAD;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> rtl/core/bpa_back.sv
// Back end: free lists, page tables, command sequencer and result register.
module bpa_back
   import bpa_pkg::*;
#(
   parameter int POOL_CAPACITY = 4096,
   parameter int TOP_RANK      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  cmd_type              cmd,
   input  logic [POOL_W-1:0]    pool_pages,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [BLOCK_W-1:0]   rsp_block_page,
   output logic [VALUE_W-1:0]   rsp_value,
   output stat_type             stat
);

   localparam int PW  = (POOL_CAPACITY > 1) ? $clog2(POOL_CAPACITY) : 1;
   localparam int NR  = TOP_RANK + 1;
   localparam int RIW = $clog2(NR);
   localparam logic [SIZE_W-1:0] CAP = SIZE_W'(POOL_CAPACITY);

   typedef enum logic [13:0] {
      S_IDLE        = 14'b00000000000001,
      S_INIT_PICK   = 14'b00000000000010,
      S_FILL        = 14'b00000000000100,
      S_ALLOC_POP   = 14'b00000000001000,
      S_ALLOC_SPLIT = 14'b00000000010000,
      S_FREE_CHK    = 14'b00000000100000,
      S_MERGE_TRY   = 14'b00000001000000,
      S_WALK        = 14'b00000010000000,
      S_WALK_NXT    = 14'b00000100000000,
      S_PUSH        = 14'b00001000000000,
      S_QUERY_RD    = 14'b00010000000000,
      S_COUNT_WALK  = 14'b00100000000000,
      S_COUNT_NXT   = 14'b01000000000000,
      S_RESP        = 14'b10000000000000
   } state_type;

   function automatic logic [RIW-1:0] ridx(input logic [RANK_W-1:0] r);
      ridx = r[RIW-1:0];
   endfunction

   function automatic logic [RANK_W-1:0] msb_rank(input logic [SIZE_W-1:0] v);
      msb_rank = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (v[i]) msb_rank = RANK_W'(i + 1);
      end
   endfunction

   // memories; next-link entries carry a valid flag above the page
   logic [PW:0]         next_link_mem [POOL_CAPACITY];
   logic [RANK_W-1:0]   rank_mem      [POOL_CAPACITY];
   logic                alloc_mem     [POOL_CAPACITY];

   logic                nl_we, rk_we, al_we;
   logic [PW-1:0]       nl_waddr, rk_waddr, al_waddr;
   logic [PW-1:0]       nl_raddr, rk_raddr, al_raddr;
   logic [PW:0]         nl_wdata, nl_rd_ff;
   logic [RANK_W-1:0]   rk_wdata, rk_rd_ff;
   logic                al_wdata, al_rd_ff;

   // free-list heads
   logic                head_vld_ff [NR];
   logic [PW-1:0]       head_pg_ff  [NR];
   logic                head_we, head_clr, head_wvld;
   logic [RIW-1:0]      head_widx;
   logic [PW-1:0]       head_wpg;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [RANK_W-1:0]   cr_ff, cr_in;
   logic [SIZE_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   cnt_ff, cnt_in;
   logic [SIZE_W-1:0]   last_ff, last_in;
   logic [SIZE_W-1:0]   off_ff, off_in;
   logic [SIZE_W-1:0]   cur_ff, cur_in;
   logic [SIZE_W-1:0]   bud_ff, bud_in;
   logic [SIZE_W-1:0]   active_ff, active_in;
   logic                walk_vld_ff, walk_vld_in;
   logic [PW-1:0]       walk_pg_ff, walk_pg_in;
   logic                prev_vld_ff, prev_vld_in;
   logic [PW-1:0]       prev_pg_ff, prev_pg_in;
   logic                merged_ff, merged_in;
   logic [VALUE_W-1:0]  count_ff, count_in;
   logic                init_ff, init_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SIZE_W-1:0]   res_block_ff, res_block_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                alloc_hit;
   logic [RANK_W-1:0]   alloc_r, init_r;
   logic [SIZE_W-1:0]   n_sat, page_ext, fill_addr, split_pg, bud_calc;

   assign page_ext = SIZE_W'(cmd.page);
   assign n_sat    = (SIZE_W'(pool_pages) > CAP) ? CAP : SIZE_W'(pool_pages);

   // smallest non-empty rank at or above the request
   always_comb begin
      alloc_hit = 1'b0;
      alloc_r   = '0;
      for (int j = TOP_RANK; j >= 1; j--) begin
         if ((RANK_W'(j) >= cmd.rank) && head_vld_ff[j]) begin
            alloc_hit = 1'b1;
            alloc_r   = RANK_W'(j);
         end
      end
   end

   // largest aligned block that fits at the carve offset
   always_comb begin
      init_r = RANK_W'(1);
      for (int j = 2; j <= TOP_RANK; j++) begin
         if ((rank_size(RANK_W'(j)) <= active_ff - off_ff) &&
             ((off_ff & (rank_size(RANK_W'(j)) - SIZE_W'(1))) == '0)) begin
            init_r = RANK_W'(j);
         end
      end
   end

   assign fill_addr = base_ff + cnt_ff;
   assign split_pg  = base_ff + rank_size(cr_ff - RANK_W'(1));
   assign bud_calc  = cur_ff ^ rank_size(cr_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cr_in         = cr_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      off_in        = off_ff;
      cur_in        = cur_ff;
      bud_in        = bud_ff;
      active_in     = active_ff;
      walk_vld_in   = walk_vld_ff;
      walk_pg_in    = walk_pg_ff;
      prev_vld_in   = prev_vld_ff;
      prev_pg_in    = prev_pg_ff;
      merged_in     = merged_ff;
      count_in      = count_ff;
      init_in       = init_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_value_in  = rsp_value_ff;
      cmd_ready     = 1'b0;
      nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0; nl_raddr = '0;
      rk_we = 1'b0; rk_waddr = '0; rk_wdata = '0; rk_raddr = '0;
      al_we = 1'b0; al_waddr = '0; al_wdata = 1'b0; al_raddr = '0;
      head_we = 1'b0; head_clr = 1'b0; head_widx = '0;
      head_wvld = 1'b0; head_wpg = '0;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in        = cmd;
               res_status_in = ST_INVAL;
               res_block_in  = '0;
               res_value_in  = '0;
               state_in      = S_RESP;
               case (cmd.op)
                  OP_INIT: begin
                     init_in   = 1'b1;
                     active_in = n_sat;
                     head_clr  = 1'b1;
                     off_in    = '0;
                     state_in  = S_INIT_PICK;
                  end
                  OP_ALLOC: begin
                     if (cmd.rank_ok) begin
                        if (alloc_hit) begin
                           base_in  = SIZE_W'(head_pg_ff[ridx(alloc_r)]);
                           cr_in    = alloc_r;
                           nl_raddr = head_pg_ff[ridx(alloc_r)];
                           state_in = S_ALLOC_POP;
                        end else begin
                           res_status_in = ST_NOSPACE;
                        end
                     end
                  end
                  OP_FREE: begin
                     if (init_ff && (page_ext < active_ff)) begin
                        rk_raddr = page_ext[PW-1:0];
                        al_raddr = page_ext[PW-1:0];
                        cur_in   = page_ext;
                        state_in = S_FREE_CHK;
                     end
                  end
                  OP_QUERY: begin
                     if (init_ff && (page_ext < active_ff)) begin
                        rk_raddr = page_ext[PW-1:0];
                        state_in = S_QUERY_RD;
                     end
                  end
                  OP_COUNT: begin
                     if (cmd.rank_ok) begin
                        walk_vld_in = head_vld_ff[ridx(cmd.rank)];
                        walk_pg_in  = head_pg_ff[ridx(cmd.rank)];
                        count_in    = '0;
                        state_in    = S_COUNT_WALK;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_INIT_PICK: begin
            if (off_ff >= active_ff) begin
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else begin
               nl_we     = 1'b1;
               nl_waddr  = off_ff[PW-1:0];
               nl_wdata  = {head_vld_ff[ridx(init_r)], head_pg_ff[ridx(init_r)]};
               head_we   = 1'b1;
               head_widx = ridx(init_r);
               head_wvld = 1'b1;
               head_wpg  = off_ff[PW-1:0];
               base_in   = off_ff;
               cnt_in    = '0;
               last_in   = rank_size(init_r) - SIZE_W'(1);
               cr_in     = init_r;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            rk_we    = 1'b1;
            rk_waddr = fill_addr[PW-1:0];
            rk_wdata = (cnt_ff < rank_size(cr_ff)) ? cr_ff : msb_rank(cnt_ff);
            al_waddr = fill_addr[PW-1:0];
            case (cmd_ff.op)
               OP_INIT: begin
                  al_we    = 1'b1;
                  al_wdata = 1'b0;
               end
               OP_ALLOC: begin
                  al_we    = (cnt_ff == '0);
                  al_wdata = 1'b1;
               end
               default: begin
                  al_we = 1'b0;
               end
            endcase
            if (cnt_ff == last_ff) begin
               if (cmd_ff.op == OP_INIT) begin
                  off_in   = fill_addr + SIZE_W'(1);
                  state_in = S_INIT_PICK;
               end else begin
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end
            end else begin
               cnt_in = cnt_ff + SIZE_W'(1);
            end
         end
         S_ALLOC_POP: begin
            head_we      = 1'b1;
            head_widx    = ridx(cr_ff);
            head_wvld    = nl_rd_ff[PW];
            head_wpg     = nl_rd_ff[PW-1:0];
            last_in      = rank_size(cr_ff) - SIZE_W'(1);
            res_block_in = base_ff;
            state_in     = S_ALLOC_SPLIT;
         end
         S_ALLOC_SPLIT: begin
            if (cr_ff > cmd_ff.rank) begin
               nl_we     = 1'b1;
               nl_waddr  = split_pg[PW-1:0];
               nl_wdata  = {head_vld_ff[ridx(cr_ff - RANK_W'(1))],
                            head_pg_ff[ridx(cr_ff - RANK_W'(1))]};
               head_we   = 1'b1;
               head_widx = ridx(cr_ff - RANK_W'(1));
               head_wvld = 1'b1;
               head_wpg  = split_pg[PW-1:0];
               cr_in     = cr_ff - RANK_W'(1);
            end else begin
               cnt_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FREE_CHK: begin
            if (!al_rd_ff) begin
               state_in = S_RESP;
            end else begin
               al_we     = 1'b1;
               al_waddr  = cur_ff[PW-1:0];
               al_wdata  = 1'b0;
               cr_in     = rk_rd_ff;
               merged_in = 1'b0;
               state_in  = S_MERGE_TRY;
            end
         end
         S_MERGE_TRY: begin
            if ((cr_ff != '0) && (cr_ff < RANK_W'(TOP_RANK)) && (bud_calc < active_ff)) begin
               bud_in      = bud_calc;
               walk_vld_in = head_vld_ff[ridx(cr_ff)];
               walk_pg_in  = head_pg_ff[ridx(cr_ff)];
               prev_vld_in = 1'b0;
               state_in    = S_WALK;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_WALK: begin
            if (!walk_vld_ff) begin
               state_in = S_PUSH;
            end else begin
               nl_raddr = walk_pg_ff;
               state_in = S_WALK_NXT;
            end
         end
         S_WALK_NXT: begin
            if (SIZE_W'(walk_pg_ff) == bud_ff) begin
               if (!prev_vld_ff) begin
                  head_we   = 1'b1;
                  head_widx = ridx(cr_ff);
                  head_wvld = nl_rd_ff[PW];
                  head_wpg  = nl_rd_ff[PW-1:0];
               end else begin
                  nl_we    = 1'b1;
                  nl_waddr = prev_pg_ff;
                  nl_wdata = nl_rd_ff;
               end
               cur_in    = (bud_ff < cur_ff) ? bud_ff : cur_ff;
               cr_in     = cr_ff + RANK_W'(1);
               merged_in = 1'b1;
               state_in  = S_MERGE_TRY;
            end else begin
               prev_vld_in = 1'b1;
               prev_pg_in  = walk_pg_ff;
               walk_vld_in = nl_rd_ff[PW];
               walk_pg_in  = nl_rd_ff[PW-1:0];
               state_in    = S_WALK;
            end
         end
         S_PUSH: begin
            nl_we     = 1'b1;
            nl_waddr  = cur_ff[PW-1:0];
            nl_wdata  = {head_vld_ff[ridx(cr_ff)], head_pg_ff[ridx(cr_ff)]};
            head_we   = 1'b1;
            head_widx = ridx(cr_ff);
            head_wvld = 1'b1;
            head_wpg  = cur_ff[PW-1:0];
            if (merged_ff) begin
               base_in  = cur_ff;
               cnt_in   = '0;
               last_in  = rank_size(cr_ff) - SIZE_W'(1);
               state_in = S_FILL;
            end else begin
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end
         end
         S_QUERY_RD: begin
            res_status_in = ST_OK;
            res_value_in  = VALUE_W'(rk_rd_ff);
            state_in      = S_RESP;
         end
         S_COUNT_WALK: begin
            if (!walk_vld_ff) begin
               res_status_in = ST_OK;
               res_value_in  = count_ff;
               state_in      = S_RESP;
            end else begin
               count_in = count_ff + VALUE_W'(1);
               nl_raddr = walk_pg_ff;
               state_in = S_COUNT_NXT;
            end
         end
         S_COUNT_NXT: begin
            walk_vld_in = nl_rd_ff[PW];
            walk_pg_in  = nl_rd_ff[PW-1:0];
            state_in    = S_COUNT_WALK;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_ff      <= 1'b0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cr_ff         <= cr_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      off_ff        <= off_in;
      cur_ff        <= cur_in;
      bud_ff        <= bud_in;
      walk_vld_ff   <= walk_vld_in;
      walk_pg_ff    <= walk_pg_in;
      prev_vld_ff   <= prev_vld_in;
      prev_pg_ff    <= prev_pg_in;
      merged_ff     <= merged_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset || head_clr) begin
         for (int i = 0; i < NR; i++) head_vld_ff[i] <= 1'b0;
      end else if (head_we) begin
         head_vld_ff[head_widx] <= head_wvld;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_pg_ff[head_widx] <= head_wpg;
      end
   end

   always_ff @(posedge clock) begin
      if (nl_we) begin
         next_link_mem[nl_waddr] <= nl_wdata;
      end
      nl_rd_ff <= next_link_mem[nl_raddr];
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rank_mem[rk_waddr] <= rk_wdata;
      end
      rk_rd_ff <= rank_mem[rk_raddr];
   end

   always_ff @(posedge clock) begin
      if (al_we) begin
         alloc_mem[al_waddr] <= al_wdata;
      end
      al_rd_ff <= alloc_mem[al_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_page   = rsp_block_ff[BLOCK_W-1:0];
   assign rsp_value        = rsp_value_ff;
   assign stat.busy        = (state_ff != S_IDLE);
   assign stat.initialized = init_ff;

endmodule

>>> rtl/core/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: front end, back end, pool size register.
//
// Request channel (req_): one word per command (func, rank, page index); valid/stall.
// Result channel (rsp_): exactly one word per request, in order; valid/stall.
// Register port (csr_): write-only pool size, always ready; sampled at init.
// Steps per command: query reads the rank table; count walks the list of its
// rank; alloc pops a block, splits it once per rank above the request and
// fills the block's page entries; free searches the list for each buddy,
// merging as it goes, and refills the merged block when merged; a page that
// starts no allocation is answered without change; init carves one block at
// a time and fills every pool page.
// Throughput is set by the single sequencer in the back end, one command at a
// time, with one next-link read per walk step.
// A two-word queue in front takes requests while the back end works, and
// the result register lets the next command start while a word waits.
// Reset clears the queue, the lists and the initialised flag; the page tables
// need no clearing pass since they are only read after init rewrites them.
// When the receiver stalls, the result word holds and the sequencer waits.
`include "buddy_page_allocator_top_macros.svh"
module buddy_page_allocator_top
   import bpa_pkg::*;
#(
   parameter int POOL_CAPACITY = 4096,
   parameter int TOP_RANK      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [RANK_W-1:0]    req_rank,
   input  logic [PAGE_W-1:0]    req_page_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [BLOCK_W-1:0]   rsp_block_page,
   output logic [VALUE_W-1:0]   rsp_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [POOL_W-1:0]    csr_pool_pages
);

   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;
   stat_type           stat;
   logic [POOL_W-1:0]  pool_pages_ff, pool_pages_in;

   // pool size register; reset value is the full 4096-page pool
   assign csr_ready     = 1'b1;
   assign pool_pages_in = (csr_valid && csr_ready) ? csr_pool_pages : pool_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_pages_ff <= POOL_W'(4096);
      end else begin
         pool_pages_ff <= pool_pages_in;
      end
   end

   bpa_front #(
      .TOP_RANK (TOP_RANK)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_rank       (req_rank),
      .req_page_index (req_page_index),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   bpa_back #(
      .POOL_CAPACITY (POOL_CAPACITY),
      .TOP_RANK      (TOP_RANK)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .pool_pages     (pool_pages_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_block_page (rsp_block_page),
      .rsp_value      (rsp_value),
      .stat           (stat)
   );

   // an accepted request word must be waiting in the queue next cycle
   `BPA_ASSERT_NEXT(a_req_queued, req_valid && !req_stall, cmd_valid, "request word lost")
   // the sequencer leaves idle once it takes a command
   `BPA_ASSERT_NEXT(a_cmd_taken, cmd_valid && cmd_ready, stat.busy, "command dropped")
   // once initialised, the pool stays initialised
   `BPA_ASSERT_NEXT(a_init_holds, stat.initialized, stat.initialized, "init flag lost")

endmodule
